// ===== src/tlpw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the two-level page walker.
// Used by tlpw_mem and the core; has no dependencies of its own.
package tlpw_pkg;

    // Physical memory geometry
    localparam int FRAME_BITS       = 12;
    localparam int PAGE_OFFSET_BITS = 6;
    localparam int PA_W             = FRAME_BITS + PAGE_OFFSET_BITS;
    // Each bank holds one byte of every 16-bit word
    localparam int WA_W             = PA_W - 1;
    localparam int BANK_DEPTH       = 1 << WA_W;
    // Index of a 16-bit entry inside one 64-byte frame
    localparam int IDX_W            = PAGE_OFFSET_BITS - 1;

    // Port widths
    localparam int VA_W    = 16;
    localparam int OUT_W   = 18;
    localparam int CFG_W   = 12;
    localparam int MODE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int ENTRY_W = 16;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_TRANSLATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

    // One memory access request for a cycle
    typedef struct packed {
        logic              rd_en;
        logic [WA_W-1:0]   rd_addr;
        logic              wr_en;
        logic [PA_W-1:0]   wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } mem_req_t;

    // Frame number held in bits 15:4 of a table entry
    function automatic logic [FRAME_BITS-1:0] entry_frame(input logic [ENTRY_W-1:0] entry);
        entry_frame = FRAME_BITS'(entry[15:4]);
    endfunction

endpackage

// ===== src/tlpw_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; no package needed.
module tlpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_q [DEPTH];

    // Write and read share the one address port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_q[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_q[addr];
        end
    end

endmodule

// ===== src/tlpw_mem.sv =====
`timescale 1ns / 1ps
// Physical byte memory split into even and odd byte banks, so that one
// 16-bit entry is read in a single access. Depends on tlpw_pkg and tlpw_ram.
module tlpw_mem
    import tlpw_pkg::*;
(
    input  logic                clk,
    input  mem_req_t            req,
    output logic [ENTRY_W-1:0]  entry
);

    logic [WA_W-1:0]   bank_addr;
    logic              even_we;
    logic              odd_we;
    logic [BYTE_W-1:0] even_rdata;
    logic [BYTE_W-1:0] odd_rdata;

    // Reads and writes never fall in the same cycle, so the port is shared
    assign bank_addr = req.wr_en ? req.wr_addr[PA_W-1:1] : req.rd_addr;
    assign even_we   = req.wr_en && !req.wr_addr[0];
    assign odd_we    = req.wr_en &&  req.wr_addr[0];

    tlpw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .re    (req.rd_en),
        .addr  (bank_addr),
        .wdata (req.wr_data),
        .rdata (even_rdata)
    );

    tlpw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .re    (req.rd_en),
        .addr  (bank_addr),
        .wdata (req.wr_data),
        .rdata (odd_rdata)
    );

    // Little-endian entry: the low byte sits at the even address
    assign entry = {odd_rdata, even_rdata};

endmodule

// ===== src/two_level_page_walker_core.sv =====
`timescale 1ns / 1ps
// Two-level page walker: command port, walk sequencer and configuration.
// Depends on tlpw_pkg and tlpw_mem.
//
// Usage
//   An item is taken at a rising edge where start is high and busy is low.
//   Modes: translate, translate and store a byte, raw physical byte write.
//   Each item yields one result, shown on fault and paddr_out for exactly
//   one cycle with done high; the receiver cannot hold results off.
//   A translation reads the directory entry, then the table entry, from the
//   banked physical memory, one access per cycle through the registered
//   bank read: busy stays high through S_PDE and S_PTE, and done rises as the
//   walker returns to idle, so no new item is taken before the walk ends.
//   An empty directory entry ends the walk early in S_PDE; done follows next.
//   The optional byte store is done in the same cycle as the table entry
//   check. A raw write or an unused mode is handled in idle; done follows in the
//   next cycle and another item may be taken there, while done is shown.
//   dir_frame is written over the cfg channel, whose ready is low while a
//   walk is in progress.
//   Reset clears the sequencer and dir_frame. Physical memory is not
//   cleared and must be written before it is read; there is no clearing pass.
module two_level_page_walker_core
    import tlpw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Command channel
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] mode,
    input  logic [VA_W-1:0]   vaddr,
    input  logic [OUT_W-1:0]  paddr_in,
    input  logic [BYTE_W-1:0] data,
    // Result channel
    output logic              done,
    output logic              fault,
    output logic [OUT_W-1:0]  paddr_out,
    // Configuration channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PDE  = 2'd1;
    localparam logic [1:0] S_PTE  = 2'd2;

    logic [1:0]                  state_reg,     state_next;
    logic                        wr_flag_reg,   wr_flag_next;
    logic [IDX_W-1:0]            tab_idx_reg,   tab_idx_next;
    logic [PAGE_OFFSET_BITS-1:0] offset_reg,    offset_next;
    logic [BYTE_W-1:0]           data_reg,      data_next;
    logic [CFG_W-1:0]            dir_frame_reg, dir_frame_next;
    logic                        done_reg,      done_next;
    logic                        fault_reg,     fault_next;
    logic [OUT_W-1:0]            paddr_reg,     paddr_next;

    mem_req_t            mem_req;
    logic [ENTRY_W-1:0]  entry;
    logic [PA_W-1:0]     walk_pa;
    logic                accept;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign walk_pa   = {entry_frame(entry), offset_reg};

    tlpw_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .entry (entry)
    );

    // Walk sequencer and memory request generation
    always_comb
    begin
        state_next     = state_reg;
        wr_flag_next   = wr_flag_reg;
        tab_idx_next   = tab_idx_reg;
        offset_next    = offset_reg;
        data_next      = data_reg;
        dir_frame_next = dir_frame_reg;
        done_next      = 1'b0;
        fault_next     = fault_reg;
        paddr_next     = paddr_reg;
        mem_req        = '0;

        if (cfg_valid && cfg_ready)
        begin
            dir_frame_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode) inside
                        MODE_TRANSLATE, MODE_WRITE:
                        begin
                            // Fetch the directory entry
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = {FRAME_BITS'(dir_frame_reg), vaddr[15:11]};
                            wr_flag_next    = (mode == MODE_WRITE);
                            tab_idx_next    = vaddr[10:6];
                            offset_next     = vaddr[5:0];
                            data_next       = data;
                            state_next      = S_PDE;
                        end
                        MODE_LOAD:
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = PA_W'(paddr_in);
                            mem_req.wr_data = data;
                            done_next       = 1'b1;
                            fault_next      = 1'b0;
                            paddr_next      = '0;
                        end
                        default:
                        begin
                            // Unused mode: no access, plain result
                            done_next  = 1'b1;
                            fault_next = 1'b0;
                            paddr_next = '0;
                        end
                    endcase
                end
            end
            S_PDE:
            begin
                if (entry == '0)
                begin
                    done_next  = 1'b1;
                    fault_next = 1'b1;
                    paddr_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Fetch the table entry from the frame the directory names
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = {entry_frame(entry), tab_idx_reg};
                    state_next      = S_PTE;
                end
            end
            S_PTE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (entry == '0)
                begin
                    fault_next = 1'b1;
                    paddr_next = '0;
                end
                else
                begin
                    fault_next      = 1'b0;
                    paddr_next      = OUT_W'(walk_pa);
                    mem_req.wr_en   = wr_flag_reg;
                    mem_req.wr_addr = walk_pa;
                    mem_req.wr_data = data_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dir_frame_reg <= '0;
            done_reg      <= 1'b0;
            fault_reg     <= 1'b0;
            paddr_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dir_frame_reg <= dir_frame_next;
            done_reg      <= done_next;
            fault_reg     <= fault_next;
            paddr_reg     <= paddr_next;
        end
    end

    // Item payload held during the walk
    always_ff @(posedge clk)
    begin
        wr_flag_reg <= wr_flag_next;
        tab_idx_reg <= tab_idx_next;
        offset_reg  <= offset_next;
        data_reg    <= data_next;
    end

    assign done      = done_reg;
    assign fault     = fault_reg;
    assign paddr_out = paddr_reg;

    // A faulting result never carries an address
    a_fault_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && fault_reg) |-> (paddr_reg == '0))
        else $error("fault result carries a non-zero address");

    // The table entry is only checked straight after the directory entry
    a_pte_after_pde: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PTE) |-> ($past(state_reg) == S_PDE))
        else $error("table entry stage entered out of order");

    // A translate item starts a walk
    a_walk_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == MODE_TRANSLATE || mode == MODE_WRITE)) |=> busy)
        else $error("translate item did not start a walk");

    // The shared bank port never sees a read and a write together
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> !mem_req.rd_en)
        else $error("memory read and write in the same cycle");

endmodule
